@@ rtl/pdf_pkg.sv @@
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types, codes and the CRC-16 byte update for the packet deframer.
// ----------------------------------------------------------------------------
package pdf_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   // Framing constants.
   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h8408;

   // Width of a payload length (0 up to 64 bytes) and of a byte position.
   localparam int LEN_W = 7;
   localparam int IDX_W = 6;

   // Frame event handed from the parser to the result stage.
   typedef struct packed {
      logic             single;   // one result, built from status and length
      logic             burst;    // stream the stored payload
      logic [1:0]       status;
      logic [7:0]       command;
      logic [LEN_W-1:0] length;
   } pdf_event_type;

   // Reflected CRC-16 update over one byte, least significant bit first.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/pdf_store.sv @@
// ----------------------------------------------------------------------------
// pdf_store
// Payload buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdf_store #(
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   localparam int DEPTH = 1 << AW;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pdf_parser.sv @@
// ----------------------------------------------------------------------------
// pdf_parser
// Frame parser: sync hunt, header, payload capture with running CRC, CRC check.
// ----------------------------------------------------------------------------
module pdf_parser
   import pdf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   parameter int AW          = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    rx_byte,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output pdf_event_type evt
);

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_CMD,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       command_ff, command_in;
   logic [7:0]       len_hi_ff, len_hi_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_hi_ff, crc_hi_in;

   logic [15:0]      declared;
   logic [LEN_W-1:0] count_inc;

   assign declared  = {len_hi_ff, rx_byte};
   assign count_inc = count_ff + LEN_W'(1);

   assign wr_en   = accept && (phase_ff == PH_DATA);
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = rx_byte;

   always_comb begin
      phase_in   = phase_ff;
      command_in = command_ff;
      len_hi_in  = len_hi_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      crc_hi_in  = crc_hi_ff;
      evt        = '0;
      evt.command = command_ff;
      if (accept) begin
         case (phase_ff)
            PH_SYNC1: begin
               phase_in = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2: begin
               phase_in = (rx_byte == SYNC_SECOND) ? PH_CMD : PH_SYNC1;
            end
            PH_CMD: begin
               command_in = rx_byte;
               phase_in   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_hi_in = rx_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (declared > 16'(MAX_PAYLOAD)) begin
                  evt.single = 1'b1;
                  evt.status = STATUS_TOO_LONG;
                  evt.length = '0;
                  phase_in   = PH_SYNC1;
               end else begin
                  length_in = LEN_W'(declared);
                  count_in  = '0;
                  crc_in    = CRC_INIT;
                  phase_in  = (declared == 16'd0) ? PH_CRC_HI : PH_DATA;
               end
            end
            PH_DATA: begin
               crc_in   = crc16_update(crc_ff, rx_byte);
               count_in = count_inc;
               if (count_inc >= length_ff) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               crc_hi_in = rx_byte;
               phase_in  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               evt.length = length_ff;
               if ({crc_hi_ff, rx_byte} != crc_ff) begin
                  evt.single = 1'b1;
                  evt.status = STATUS_CRC_BAD;
               end else if (length_ff == '0) begin
                  evt.single = 1'b1;
                  evt.status = STATUS_GOOD;
               end else begin
                  evt.burst  = 1'b1;
                  evt.status = STATUS_GOOD;
               end
               phase_in = PH_SYNC1;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         command_ff <= '0;
         len_hi_ff  <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         crc_ff     <= CRC_INIT;
         crc_hi_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         command_ff <= command_in;
         len_hi_ff  <= len_hi_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         crc_hi_ff  <= crc_hi_in;
      end
   end

endmodule

@@ rtl/pdf_emitter.sv @@
// ----------------------------------------------------------------------------
// pdf_emitter
// Result stage: output register, and the read sequencer that streams a good
// payload out of the store.
// ----------------------------------------------------------------------------
module pdf_emitter
   import pdf_pkg::*;
#(
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  pdf_event_type    evt,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   input  logic [7:0]       rd_data,
   output logic             in_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_command,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last
);

   logic             valid_ff, valid_in;
   logic [1:0]       status_ff, status_in;
   logic [7:0]       command_ff, command_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic             emitting_ff, emitting_in;
   logic [7:0]       burst_cmd_ff, burst_cmd_in;
   logic [LEN_W-1:0] burst_len_ff, burst_len_in;
   logic [LEN_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic out_free;
   logic move;
   logic issue;
   logic move_last;

   assign out_free  = !valid_ff || !rsp_stall;
   assign move      = pend_ff && out_free;
   assign issue     = emitting_ff && (issue_cnt_ff != burst_len_ff) && (!pend_ff || move);
   assign move_last = (LEN_W'(pend_idx_ff) + LEN_W'(1)) == burst_len_ff;

   assign rd_en    = issue;
   assign rd_addr  = issue_cnt_ff[AW-1:0];
   assign in_stall = emitting_ff || (valid_ff && rsp_stall);

   always_comb begin
      valid_in     = valid_ff && rsp_stall;
      status_in    = status_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      index_in     = index_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      emitting_in  = emitting_ff;
      burst_cmd_in = burst_cmd_ff;
      burst_len_in = burst_len_ff;
      issue_cnt_in = issue_cnt_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;

      if (evt.single) begin
         valid_in   = 1'b1;
         status_in  = evt.status;
         command_in = evt.command;
         length_in  = evt.length;
         index_in   = '0;
         byte_in    = '0;
         last_in    = 1'b1;
      end

      if (evt.burst) begin
         emitting_in  = 1'b1;
         burst_cmd_in = evt.command;
         burst_len_in = evt.length;
         issue_cnt_in = '0;
         pend_in      = 1'b0;
      end

      if (move) begin
         valid_in   = 1'b1;
         status_in  = STATUS_GOOD;
         command_in = burst_cmd_ff;
         length_in  = burst_len_ff;
         index_in   = pend_idx_ff;
         byte_in    = rd_data;
         last_in    = move_last;
         pend_in    = 1'b0;
         if (move_last) begin
            emitting_in = 1'b0;
         end
      end

      if (issue) begin
         pend_in      = 1'b1;
         pend_idx_in  = issue_cnt_ff[IDX_W-1:0];
         issue_cnt_in = issue_cnt_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         emitting_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         emitting_ff <= emitting_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      command_ff   <= command_in;
      length_ff    <= length_in;
      index_ff     <= index_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      burst_cmd_ff <= burst_cmd_in;
      burst_len_ff <= burst_len_in;
      issue_cnt_ff <= issue_cnt_in;
      pend_idx_ff  <= pend_idx_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_command        = command_ff;
   assign rsp_payload_length = length_ff;
   assign rsp_byte_index     = index_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_last           = last_ff;

endmodule

@@ rtl/packet_deframer_crc16_check_unit.sv @@
// ----------------------------------------------------------------------------
// packet_deframer_crc16_check_unit
// Sync A5 5A deframer with big-endian length and reflected CRC-16 check.
// ----------------------------------------------------------------------------
// Timing: a single result (too long, CRC mismatch, empty good packet) is
// offered in the cycle after its byte is transferred. A good packet's first
// byte passes the burst flag, the store read and the output register; after it
// comes one byte per cycle while the sink keeps taking them.
// Throughput: one input byte per cycle; input stalls for a payload burst and
// for a stalled result. Reset clears parser and result control, not the store.
module packet_deframer_crc16_check_unit
   import pdf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_command,
   output logic [LEN_W-1:0] rsp_payload_length,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last
);

   // The payload buffer holds up to MAX_PAYLOAD bytes; its address is at least
   // one bit wide so that a one-byte buffer still has a legal index.
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic          accept;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   pdf_event_type evt;

   // A byte transfer happens whenever the source offers one and we do not
   // stall. We stall while a good payload is being streamed out of the store,
   // and while the output register holds a result that the sink has not taken.
   // This also keeps reads and writes of the store from ever overlapping.
   assign accept = req_valid && !req_stall;

   // The parser walks the frame one byte per transfer, writes payload bytes
   // into the store and keeps the running CRC. It raises one event per frame
   // outcome.
   pdf_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .evt     (evt)
   );

   // Payload store with registered read data.
   pdf_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The emitter owns the output register. For a good packet it reads the
   // store ahead by one entry and holds the fetched byte while the sink stalls.
   pdf_emitter #(
      .AW (AW)
   ) u_emitter (
      .clock              (clock),
      .reset              (reset),
      .evt                (evt),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .in_stall           (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

endmodule

@@ rtl/pdf_checker.sv @@
// ----------------------------------------------------------------------------
// pdf_checker
// Port-level assertions for the packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module pdf_checker
   import pdf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_status,
   input logic [7:0]       rsp_command,
   input logic [LEN_W-1:0] rsp_payload_length,
   input logic [IDX_W-1:0] rsp_byte_index,
   input logic [7:0]       rsp_payload_byte,
   input logic             rsp_last
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_command) &&
         $stable(rsp_byte_index) && $stable(rsp_payload_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // Error results are single, final results with no payload byte.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_CRC_BAD || rsp_status == STATUS_TOO_LONG)
         |-> rsp_last && rsp_byte_index == '0 && rsp_payload_byte == '0)
      else $error("error result is not a lone final result");

   // A payload byte position always lies inside the payload, and the final
   // byte of a good packet sits at the end.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_GOOD && rsp_payload_length != '0
         |-> (LEN_W'(rsp_byte_index) < rsp_payload_length) &&
             (rsp_last == ((LEN_W'(rsp_byte_index) + LEN_W'(1)) == rsp_payload_length)))
      else $error("byte position or last flag inconsistent with length");

   // While results are still stalled, no new input byte is taken.
   a_in_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while a result waits");

endmodule

bind packet_deframer_crc16_check_unit pdf_checker u_pdf_checker (.*);

@@ dv/deframer_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_check
// Watches both channels of the packet deframer, rebuilds the expected result
// stream from the accepted bytes and compares every result that comes out.
// ----------------------------------------------------------------------------
module deframer_check
   import pdf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [1:0]       rsp_status,
   input  logic [7:0]       rsp_command,
   input  logic [LEN_W-1:0] rsp_payload_length,
   input  logic [IDX_W-1:0] rsp_byte_index,
   input  logic [7:0]       rsp_payload_byte,
   input  logic             rsp_last,
   output int               fail_count,
   output int               results_due
);

   typedef enum logic [3:0] {
      HUNT_FIRST,
      HUNT_SECOND,
      GET_CMD,
      GET_LEN_HI,
      GET_LEN_LO,
      GET_DATA,
      GET_CRC_HI,
      GET_CRC_LO
   } frame_phase_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       command;
      logic [LEN_W-1:0] length;
      logic [IDX_W-1:0] index;
      logic [7:0]       data;
      logic             last;
   } frame_result_type;

   frame_result_type frame_results_due[$];

   frame_phase_type frame_phase;
   logic [7:0]      frame_command;
   logic [15:0]     frame_length;
   logic [6:0]      frame_count;
   logic [15:0]     frame_crc;
   logic [7:0]      frame_crc_high;
   logic [7:0]      payload_copy [64];
   int              results_seen;

   // Bit-serial form of the reflected CRC: feedback is the low CRC bit
   // xored with the next data bit, least significant data bit first.
   function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                            input logic [7:0]  data);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb  = crc[0] ^ data[k];
         crc = crc >> 1;
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] deframer_check: %s", $time, what);
   endtask

   task automatic queue_result(input logic [1:0]       status,
                               input logic [LEN_W-1:0] length,
                               input logic [IDX_W-1:0] index,
                               input logic [7:0]       data,
                               input logic             last);
      frame_results_due.push_back('{status, frame_command, length, index, data, last});
   endtask

   task automatic parse_rx_byte(input logic [7:0] rx);
      logic [15:0] crc_rx;
      int          len;
      case (frame_phase)
         HUNT_SECOND: begin
            frame_phase = (rx == SYNC_SECOND) ? GET_CMD : HUNT_FIRST;
         end
         GET_CMD: begin
            frame_command = rx;
            frame_phase   = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            frame_length = {8'h00, rx};
            frame_phase  = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            frame_length = {frame_length[7:0], rx};
            if (frame_length > MAX_PAYLOAD) begin
               queue_result(STATUS_TOO_LONG, '0, '0, 8'h00, 1'b1);
               frame_phase = HUNT_FIRST;
            end else begin
               frame_count = '0;
               frame_crc   = CRC_INIT;
               frame_phase = (frame_length == 16'd0) ? GET_CRC_HI : GET_DATA;
            end
         end
         GET_DATA: begin
            payload_copy[frame_count[5:0]] = rx;
            frame_crc   = crc_fold(frame_crc, rx);
            frame_count = frame_count + 7'd1;
            if (frame_count >= frame_length) begin
               frame_phase = GET_CRC_HI;
            end
         end
         GET_CRC_HI: begin
            frame_crc_high = rx;
            frame_phase    = GET_CRC_LO;
         end
         GET_CRC_LO: begin
            crc_rx = {frame_crc_high, rx};
            len    = (frame_length > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(frame_length);
            if (crc_rx != frame_crc) begin
               queue_result(STATUS_CRC_BAD, LEN_W'(len), '0, 8'h00, 1'b1);
            end else if (len == 0) begin
               queue_result(STATUS_GOOD, '0, '0, 8'h00, 1'b1);
            end else begin
               for (int i = 0; i < len; i++) begin
                  queue_result(STATUS_GOOD, LEN_W'(len), IDX_W'(i), payload_copy[i],
                               i == len - 1);
               end
            end
            frame_phase = HUNT_FIRST;
         end
         default: begin
            frame_phase = (rx == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
         end
      endcase
   endtask

   task automatic compare_result();
      frame_result_type got;
      frame_result_type want;
      got = '{rsp_status, rsp_command, rsp_payload_length, rsp_byte_index,
              rsp_payload_byte, rsp_last};
      if (frame_results_due.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
      end else begin
         want = frame_results_due.pop_front();
         if (got !== want) begin
            report_mismatch($sformatf({"result %0d: want st=%0d cmd=%02h len=%0d idx=%0d ",
               "byte=%02h last=%0d, got st=%0d cmd=%02h len=%0d idx=%0d byte=%02h last=%0d"},
               results_seen, want.status, want.command, want.length, want.index,
               want.data, want.last, got.status, got.command, got.length, got.index,
               got.data, got.last));
         end
      end
      results_seen++;
   endtask

   // Results are taken before bytes: a byte transferred at this edge cannot
   // cause a result at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         frame_phase    = HUNT_FIRST;
         frame_command  = '0;
         frame_length   = '0;
         frame_count    = '0;
         frame_crc      = CRC_INIT;
         frame_crc_high = '0;
         results_seen   = 0;
         frame_results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_result();
         end
         if (req_valid && !req_stall) begin
            parse_rx_byte(req_rx_byte);
         end
      end
      results_due = frame_results_due.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives framed byte streams into the packet deframer with CRC-16 check:
// a short directed opening on sync, length and CRC corner cases, then random
// frames, noise and broken headers, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;
   import pdf_pkg::*;

   localparam int MAX_BYTES = 64;

   // All block inputs hold a known value from time zero.
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_stall   = 1'b0;

   logic             req_stall;
   logic             rsp_valid;
   logic [1:0]       rsp_status;
   logic [7:0]       rsp_command;
   logic [LEN_W-1:0] rsp_payload_length;
   logic [IDX_W-1:0] rsp_byte_index;
   logic [7:0]       rsp_payload_byte;
   logic             rsp_last;

   int fail_count;
   int results_due;

   // Sender burst bookkeeping and a count of transferred bytes.
   int burst_left = 0;
   int bytes_sent = 0;

   // Receiver stall pattern: a mode held for a random stretch of cycles.
   int stall_mode = 0;
   int stall_run  = 0;

   always #2 clock = ~clock;

   packet_deframer_crc16_check_unit #(
      .MAX_PAYLOAD(MAX_BYTES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

   // The checker sees exactly what the block sees and hands back how many
   // failures it found and how many results are still owed.
   deframer_check #(
      .MAX_PAYLOAD(MAX_BYTES)
   ) u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .results_due        (results_due)
   );

   // The sink switches between never stalling, light stalls, heavy stalls and
   // strict alternation, so stalls land on every position of a payload burst.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(8, 64);
      end else begin
         stall_run = stall_run - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= ~rsp_stall;
         end
      endcase
   end

   // CRC used only to build the check values of the frames that are sent.
   function automatic logic [15:0] frame_crc_step(input logic [15:0] crc,
                                                  input logic [7:0]  data);
      crc = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

   // Presents one byte and returns right after the edge that transfers it.
   // A new burst may start with an idle gap; valid is only lowered when the
   // gap is not zero, so it never drops and rises in one step.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      burst_left = burst_left - 1;
      bytes_sent = bytes_sent + 1;
   endtask

   // Sends sync pair, command and big-endian length. Lengths within the limit
   // get a random payload and a big-endian CRC, optionally corrupted; longer
   // lengths end at the header, as the block drops back to hunting there.
   task automatic send_frame(input logic [7:0]  command,
                             input logic [15:0] length,
                             input bit          bad_crc);
      logic [15:0] crc;
      logic [7:0]  data;
      crc = CRC_INIT;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(command);
      send_byte(length[15:8]);
      send_byte(length[7:0]);
      if (length <= MAX_BYTES) begin
         for (int i = 0; i < int'(length); i++) begin
            data = 8'($urandom);
            crc  = frame_crc_step(crc, data);
            send_byte(data);
         end
         if (bad_crc) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
         end
         send_byte(crc[15:8]);
         send_byte(crc[7:0]);
      end
   endtask

   initial begin
      int          pick;
      int          len;
      logic [7:0]  len_hi;
      logic [7:0]  len_lo;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A second A5 in place of 5A must not re-arm the sync hunt, so the
      // trailing 5A here is just noise.
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      // One past the payload limit is rejected right after the length.
      send_frame(8'h00, 16'(MAX_BYTES + 1), 1'b0);
      // Empty payload: the CRC follows the length and must equal the init.
      send_frame(8'h3C, 16'd0, 1'b0);
      // Empty payload with a wrong CRC.
      send_frame(8'hC3, 16'd0, 1'b1);
      // Smallest real payload.
      send_frame(8'hFF, 16'd1, 1'b0);

      // Mostly well-formed frames with random content; the rest is rejected
      // lengths, line noise and headers cut short.
      while (bytes_sent < 490) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 19)) inside
               [0:11]:  len = $urandom_range(0, 8);
               [12:16]: len = $urandom_range(9, MAX_BYTES - 1);
               default: len = MAX_BYTES;
            endcase
            send_frame(8'($urandom), 16'(len), $urandom_range(0, 6) == 0);
         end else if (pick < 82) begin
            len_hi = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            len_lo = (len_hi == 8'h00) ? 8'($urandom_range(MAX_BYTES + 1, 255))
                                       : 8'($urandom);
            send_frame(8'($urandom), {len_hi, len_lo}, 1'b0);
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 6)) begin
               send_byte(($urandom_range(0, 2) == 0) ? SYNC_FIRST : 8'($urandom));
            end
         end else begin
            // Header cut after the command: following bytes become the length.
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            send_byte(8'($urandom));
         end
      end
      req_valid <= 1'b0;

      // Drain every owed result, then give stray results time to show up.
      do @(posedge clock); while (results_due != 0);
      repeat (40) @(posedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
